// ----- hdl/svme_pkg.sv -----
// Shared types and constants for the six-field varint message encoder.
`default_nettype none
package svme_pkg;

    localparam int unsigned VALUE_W     = 32;
    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned GROUP_W     = 7;
    localparam int unsigned FIELD_COUNT = 6;
    localparam int unsigned FIELD_W     = 3;
    localparam int unsigned WIRE_W      = 3;

    localparam logic [BYTE_W-1:0]  HEADER_BYTE = 8'h03;
    localparam logic [WIRE_W-1:0]  WIRE_VARINT = 3'b000;
    localparam logic [FIELD_W-1:0] FIELD_FIRST = 3'd1;
    localparam logic [FIELD_W-1:0] FIELD_FINAL = 3'(FIELD_COUNT);

    typedef logic [1:0] t_sel;
    localparam t_sel SEL_HDR = 2'd0;
    localparam t_sel SEL_TAG = 2'd1;
    localparam t_sel SEL_VAL = 2'd2;

    typedef logic [VALUE_W-1:0] t_value;

    typedef struct packed {
        logic               load_in;
        logic               load_cur;
        logic               shift;
        logic               emit;
        logic               last;
        t_sel               sel;
        logic [FIELD_W-1:0] field;
    } t_dp_cmd;

    typedef struct packed {
        logic more;
        logic out_free;
    } t_dp_sts;

endpackage
`default_nettype wire

// ----- hdl/svme_dp.sv -----
// Datapath: field store, varint shifter and output register.
`default_nettype none
module svme_dp import svme_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire t_dp_cmd i_cmd,
    output t_dp_sts      o_sts,
    input  wire t_value  i_power_watts,
    input  wire t_value  i_cadence_rpm,
    input  wire t_value  i_speed_hundredths,
    input  wire t_value  i_heart_rate,
    input  wire t_value  i_extra_one,
    input  wire t_value  i_extra_two,
    output logic         o_out_valid,
    input  wire logic    i_out_stall,
    output logic [BYTE_W-1:0] o_out_byte,
    output logic         o_is_last
);

    t_value              r_fields [FIELD_COUNT];
    t_value              r_cur;
    logic [BYTE_W-1:0]   r_byte;
    logic                r_last;
    logic                r_valid;
    logic [BYTE_W-1:0]   n_byte;
    logic                w_more;

    assign w_more = |r_cur[VALUE_W-1:GROUP_W];

    always_comb begin
        unique case (i_cmd.sel)
            SEL_HDR: n_byte = HEADER_BYTE;
            SEL_TAG: n_byte = {2'b00, i_cmd.field, WIRE_VARINT};
            SEL_VAL: n_byte = {w_more, r_cur[GROUP_W-1:0]};
            default: n_byte = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_fields[0] <= i_power_watts;
            r_fields[1] <= i_cadence_rpm;
            r_fields[2] <= i_speed_hundredths;
            r_fields[3] <= i_heart_rate;
            r_fields[4] <= i_extra_one;
            r_fields[5] <= i_extra_two;
        end else if (i_cmd.load_cur) begin
            for (int k = 0; k < FIELD_COUNT - 1; k++) begin
                r_fields[k] <= r_fields[k+1];
            end
        end
        if (i_cmd.load_cur) begin
            r_cur <= r_fields[0];
        end else if (i_cmd.shift) begin
            r_cur <= r_cur >> GROUP_W;
        end
        if (i_cmd.emit) begin
            r_byte <= n_byte;
            r_last <= i_cmd.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_valid <= 1'b0;
        end
    end

    assign o_sts.more     = w_more;
    assign o_sts.out_free = !r_valid || !i_out_stall;
    assign o_out_valid    = r_valid;
    assign o_out_byte     = r_byte;
    assign o_is_last      = r_last;

endmodule
`default_nettype wire

// ----- hdl/svme_ctrl.sv -----
// Controller: sequences header, tag and varint bytes of one message.
`default_nettype none
module svme_ctrl import svme_pkg::*; (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    output logic         o_in_stall,
    input  wire t_dp_sts i_sts,
    output t_dp_cmd      o_cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_HDR  = 2'd1;
    localparam logic [1:0] ST_TAG  = 2'd2;
    localparam logic [1:0] ST_VAL  = 2'd3;

    logic [1:0]         r_state;
    logic [1:0]         n_state;
    logic [FIELD_W-1:0] r_field;
    logic [FIELD_W-1:0] n_field;
    logic               w_busy;
    logic               w_emit;

    assign w_busy = (r_state != ST_IDLE);
    assign w_emit = w_busy && i_sts.out_free;

    always_comb begin
        n_state        = r_state;
        n_field        = r_field;
        o_cmd.load_in  = 1'b0;
        o_cmd.load_cur = 1'b0;
        o_cmd.shift    = 1'b0;
        o_cmd.emit     = w_emit;
        o_cmd.last     = 1'b0;
        o_cmd.sel      = SEL_HDR;
        o_cmd.field    = r_field;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_field       = FIELD_FIRST;
                    n_state       = ST_HDR;
                end
            end
            ST_HDR: begin
                o_cmd.sel = SEL_HDR;
                if (w_emit) begin
                    n_state = ST_TAG;
                end
            end
            ST_TAG: begin
                o_cmd.sel = SEL_TAG;
                if (w_emit) begin
                    o_cmd.load_cur = 1'b1;
                    n_state        = ST_VAL;
                end
            end
            ST_VAL: begin
                o_cmd.sel  = SEL_VAL;
                o_cmd.last = !i_sts.more && (r_field == FIELD_FINAL);
                if (w_emit) begin
                    o_cmd.shift = 1'b1;
                    if (!i_sts.more) begin
                        if (r_field == FIELD_FINAL) begin
                            n_state = ST_IDLE;
                        end else begin
                            n_field = r_field + FIELD_W'(1);
                            n_state = ST_TAG;
                        end
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_field <= FIELD_FIRST;
        end else begin
            r_state <= n_state;
            r_field <= n_field;
        end
    end

    assign o_in_stall = w_busy;

endmodule
`default_nettype wire

// ----- hdl/six_field_varint_message_encoder_unit.sv -----
// Top level of the six-field varint message encoder.
// Input channel: i_in_valid / o_in_stall with six 32-bit field values.
// Output channel: o_out_valid / i_out_stall with one message byte per
// transaction and o_is_last marking the final byte.
// A message is the header byte 0x03, then for fields 1 to 6 a tag byte
// (field number << 3) and the value as a base-128 varint, low group first.
// After an input transaction the header state emits the header byte.
// Throughput: one byte per cycle while the receiver takes them; a message
// of 13 to 37 bytes is sent by the single byte sequencer through the
// one-byte output register.
// o_in_stall is high while a message is being sequenced; the next input
// transaction is taken as soon as the final byte sits in the output
// register, even while that byte is still stalled.
// A stalled output byte is held and the sequencer waits.
// Reset clears the sequencer and the output valid; no message is pending.
`default_nettype none
module six_field_varint_message_encoder_unit import svme_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire t_value      i_power_watts,
    input  wire t_value      i_cadence_rpm,
    input  wire t_value      i_speed_hundredths,
    input  wire t_value      i_heart_rate,
    input  wire t_value      i_extra_one,
    input  wire t_value      i_extra_two,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [BYTE_W-1:0] o_out_byte,
    output logic             o_is_last
);

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    svme_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    svme_dp u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (w_cmd),
        .o_sts              (w_sts),
        .i_power_watts      (i_power_watts),
        .i_cadence_rpm      (i_cadence_rpm),
        .i_speed_hundredths (i_speed_hundredths),
        .i_heart_rate       (i_heart_rate),
        .i_extra_one        (i_extra_one),
        .i_extra_two        (i_extra_two),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_out_byte         (o_out_byte),
        .o_is_last          (o_is_last)
    );

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("sequencer not busy after input transaction");

    a_last_frees_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.emit && w_cmd.last) |=> !o_in_stall)
        else $error("input still stalled after final byte");

    a_last_from_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.last |-> (w_cmd.sel == SEL_VAL && !w_sts.more))
        else $error("final byte flagged outside last varint group");

    a_emit_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.emit |-> w_sts.out_free)
        else $error("byte emitted into occupied output register");

endmodule
`default_nettype wire

// ----- verif/tb_six_field_varint_message_encoder_unit.sv -----
// Testbench for the six-field varint message encoder: directed table, random messages, byte checks.
`timescale 1ns / 1ps
module tb_six_field_varint_message_encoder_unit import svme_pkg::*;;

    localparam int MAX_MSG_LEN  = 37;
    localparam int NUM_RANDOM   = 200;
    localparam int QUIET_ITEMS  = 30;
    localparam int HOLD_CYCLES  = 400;
    localparam int HOLD_TRIGGER = 30;
    localparam int IDLE_LIMIT   = 2000;
    localparam int DRAIN_CYCLES = 40;

    typedef enum logic [1:0] {
        LIT_NONE,
        LIT_ZERO,
        LIT_MAX
    } t_lit;

    typedef struct {
        t_lit   lit;
        t_value vals [FIELD_COUNT];
    } t_row;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              last;
    } t_msg_byte;

    localparam logic [BYTE_W-1:0] ZERO_MSG [13] = '{
        8'h03, 8'h08, 8'h00, 8'h10, 8'h00, 8'h18, 8'h00,
        8'h20, 8'h00, 8'h28, 8'h00, 8'h30, 8'h00
    };

    localparam logic [BYTE_W-1:0] MAX_MSG [MAX_MSG_LEN] = '{
        8'h03,
        8'h08, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h0F,
        8'h10, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h0F,
        8'h18, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h0F,
        8'h20, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h0F,
        8'h28, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h0F,
        8'h30, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h0F
    };

    localparam int NUM_DIRECTED = 12;
    t_row directed_rows [NUM_DIRECTED] = '{
        '{LIT_ZERO, '{32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0}},
        '{LIT_MAX,  '{32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF,
                      32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF}},
        '{LIT_NONE, '{32'd1, 32'd127, 32'd128, 32'd16383, 32'd16384, 32'd2097151}},
        '{LIT_NONE, '{32'd2097152, 32'd268435455, 32'd268435456,
                      32'h80000000, 32'h7FFFFFFF, 32'hFFFFFFFF}},
        '{LIT_NONE, '{32'hAAAAAAAA, 32'hAAAAAAAA, 32'hAAAAAAAA,
                      32'h55555555, 32'h55555555, 32'h55555555}},
        '{LIT_NONE, '{32'h55555555, 32'h55555555, 32'h55555555,
                      32'hAAAAAAAA, 32'hAAAAAAAA, 32'hAAAAAAAA}},
        '{LIT_NONE, '{32'h0, 32'hFFFFFFFF, 32'h0, 32'hFFFFFFFF, 32'h0, 32'hFFFFFFFF}},
        '{LIT_NONE, '{32'hFFFFFFFF, 32'h0, 32'hFFFFFFFF, 32'h0, 32'hFFFFFFFF, 32'h0}},
        '{LIT_NONE, '{32'd250, 32'd90, 32'd3250, 32'd142, 32'd1, 32'd2}},
        '{LIT_NONE, '{32'h0FFFFFFF, 32'h10000000, 32'h3FFF, 32'h4000, 32'h7F, 32'h80}},
        '{LIT_NONE, '{32'h1, 32'h40, 32'h2000, 32'h100000, 32'h8000000, 32'h80000000}},
        '{LIT_NONE, '{32'h80, 32'h4000, 32'h200000, 32'h10000000, 32'h1, 32'h0}}
    };

    logic              i_clk;
    logic              i_rst_n;
    logic              i_in_valid;
    logic              o_in_stall;
    t_value            i_power_watts;
    t_value            i_cadence_rpm;
    t_value            i_speed_hundredths;
    t_value            i_heart_rate;
    t_value            i_extra_one;
    t_value            i_extra_two;
    logic              o_out_valid;
    logic              i_out_stall;
    logic [BYTE_W-1:0] o_out_byte;
    logic              o_is_last;

    t_msg_byte pending_bytes [$];
    int        fails;
    int        items_accepted;
    bit        quiet;
    bit        pressure_done;

    six_field_varint_message_encoder_unit dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_power_watts      (i_power_watts),
        .i_cadence_rpm      (i_cadence_rpm),
        .i_speed_hundredths (i_speed_hundredths),
        .i_heart_rate       (i_heart_rate),
        .i_extra_one        (i_extra_one),
        .i_extra_two        (i_extra_two),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_out_byte         (o_out_byte),
        .o_is_last          (o_is_last)
    );

    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int encode_message(input t_value vals [FIELD_COUNT],
                                          output logic [BYTE_W-1:0] msg [MAX_MSG_LEN]);
        int                n;
        t_value            rest;
        logic [BYTE_W-1:0] grp;
        logic [BYTE_W-1:0] tag;
        n = 0;
        for (int i = 0; i < MAX_MSG_LEN; i++) msg[i] = '0;
        msg[n] = HEADER_BYTE;
        n = n + 1;
        for (int f = 0; f < FIELD_COUNT; f++) begin
            tag = BYTE_W'((f + 1) << WIRE_W) | BYTE_W'(WIRE_VARINT);
            for (int k = 0; k < 2; k++) begin
                rest = (k == 0) ? t_value'(tag) : vals[f];
                do begin
                    grp  = {1'b0, rest[GROUP_W-1:0]};
                    rest = rest >> GROUP_W;
                    if (rest != '0) grp[BYTE_W-1] = 1'b1;
                    msg[n] = grp;
                    n = n + 1;
                end while (rest != '0);
            end
        end
        return n;
    endfunction

    function automatic t_value rand_field();
        t_value v;
        int     groups;
        v = $urandom;
        case ($urandom_range(0, 9))
            0: v = '0;
            1: v = '1;
            default: begin
                groups = $urandom_range(1, 5);
                if (groups < 5) begin
                    v = v & ((t_value'(1) << (GROUP_W * groups)) - 1);
                    if ($urandom_range(0, 1) == 1) v[GROUP_W * groups - 1] = 1'b1;
                end
            end
        endcase
        return v;
    endfunction

    // Called in a falling-edge time step; returns in the falling-edge step after acceptance.
    task automatic offer_message(input t_value vals [FIELD_COUNT], input t_lit lit);
        logic [BYTE_W-1:0] msg [MAX_MSG_LEN];
        int                n;
        int                gap;
        gap = 0;
        if (!quiet && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 14);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid         <= 1'b1;
        i_power_watts      <= vals[0];
        i_cadence_rpm      <= vals[1];
        i_speed_hundredths <= vals[2];
        i_heart_rate       <= vals[3];
        i_extra_one        <= vals[4];
        i_extra_two        <= vals[5];
        do @(posedge i_clk); while (o_in_stall);
        items_accepted = items_accepted + 1;
        case (lit)
            LIT_ZERO: begin
                n = 13;
                for (int i = 0; i < n; i++) msg[i] = ZERO_MSG[i];
            end
            LIT_MAX: begin
                n = MAX_MSG_LEN;
                for (int i = 0; i < n; i++) msg[i] = MAX_MSG[i];
            end
            default: n = encode_message(vals, msg);
        endcase
        for (int i = 0; i < n; i++) pending_bytes.push_back('{msg[i], i == n - 1});
        @(negedge i_clk);
    endtask

    initial begin
        t_value vals [FIELD_COUNT];
        i_rst_n            = 1'b0;
        i_in_valid         = 1'b0;
        i_power_watts      = '0;
        i_cadence_rpm      = '0;
        i_speed_hundredths = '0;
        i_heart_rate       = '0;
        i_extra_one        = '0;
        i_extra_two        = '0;
        fails              = 0;
        items_accepted     = 0;
        quiet              = 1'b0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        for (int r = 0; r < NUM_DIRECTED; r++)
            offer_message(directed_rows[r].vals, directed_rows[r].lit);
        for (int r = 0; r < NUM_RANDOM; r++) begin
            if (r >= NUM_RANDOM - QUIET_ITEMS) quiet = 1'b1;
            for (int f = 0; f < FIELD_COUNT; f++) vals[f] = rand_field();
            offer_message(vals, LIT_NONE);
        end
        i_in_valid <= 1'b0;
        while (pending_bytes.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fails == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    initial begin
        int  len;
        bit  lvl;
        i_out_stall   = 1'b0;
        pressure_done = 1'b0;
        forever begin
            if (!pressure_done && items_accepted >= HOLD_TRIGGER) begin
                pressure_done = 1'b1;
                @(negedge i_clk);
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES - 1) @(negedge i_clk);
            end else if (quiet || !i_rst_n) begin
                @(negedge i_clk);
                i_out_stall <= 1'b0;
            end else begin
                lvl = ($urandom_range(0, 2) == 0);
                len = lvl ? $urandom_range(1, 14) : $urandom_range(1, 30);
                repeat (len) begin
                    @(negedge i_clk);
                    i_out_stall <= lvl;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        t_msg_byte want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_bytes.size() == 0) begin
                $error("out_byte with no message byte pending: actual %02h", o_out_byte);
                fails = fails + 1;
            end else begin
                want = pending_bytes.pop_front();
                if (o_out_byte !== want.data) begin
                    $error("out_byte mismatch: expected %02h, actual %02h",
                           want.data, o_out_byte);
                    fails = fails + 1;
                end
                if (o_is_last !== want.last) begin
                    $error("is_last mismatch: expected %0b, actual %0b", want.last, o_is_last);
                    fails = fails + 1;
                end
            end
        end
    end

    initial begin
        int idle;
        idle = 0;
        while (idle < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
                idle = 0;
            else
                idle = idle + 1;
        end
        $display("simulation failed");
        $finish;
    end

endmodule
